// ===== rtl/core/fct_pkg.sv =====
`default_nettype none

package fct_pkg;

  // Field widths.
  localparam int COORD_W   = 32;
  localparam int DIR_W     = 16;
  localparam int CFG_W     = (3 * DIR_W > COORD_W) ? 3 * DIR_W : COORD_W;
  localparam int CFG_IDX_W = 3;

  // Basis vectors are signed Q2.30.
  localparam int BW   = 32;
  localparam int FRAC = 30;

  // Working widths of the basis builder.
  localparam int TW        = 64;
  localparam int WW        = 128;
  localparam int NORM_BITS = 20;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic FUNC_TO_FRAME = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIR_W-1:0]   dir_t;
  typedef logic signed [BW-1:0]      coef_t;
  typedef coef_t [2:0]               vec_t;
  typedef coord_t [2:0]              point_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_AXIS     = 3'd3,
    CFG_UP       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic   func;
    coord_t in_x;
    coord_t in_y;
    coord_t in_z;
  } in_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   degenerate;
  } out_item_t;

  // Frame state handed from the basis builder to the datapath.
  typedef struct packed {
    logic   ready;
    logic   degen;
    point_t origin;
    vec_t   bx;
    vec_t   by;
    vec_t   bz;
  } frame_t;

  // One classified point waiting in the queue.
  typedef struct packed {
    logic   func;
    logic   degen;
    point_t pt;
  } q_item_t;

  typedef enum logic [3:0] {
    BS_LOAD,
    BS_MLOAD,
    BS_MRUN,
    BS_MSTORE,
    BS_SHIFT,
    BS_SQRT,
    BS_DLOAD,
    BS_DRUN,
    BS_DSTORE,
    BS_DONE
  } basis_state_t;

  typedef enum logic [2:0] {
    MP_SQ,
    MP_PAR,
    MP_CROSS,
    MP_NORM,
    MP_YHAT
  } mul_phase_t;

endpackage

`default_nettype wire

// ===== rtl/core/fct_basis.sv =====
`default_nettype none

module fct_basis (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fct_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fct_pkg::CFG_W-1:0]           cfg_data,
  output fct_pkg::frame_t                     frame
);

  localparam int TW = fct_pkg::TW;
  localparam int WW = fct_pkg::WW;
  localparam logic signed [TW-1:0] Y_HALF = TW'(1) <<< (fct_pkg::FRAC - 1);

  function automatic logic [TW-1:0] abs_t(input logic signed [TW-1:0] v);
    abs_t = v[TW-1] ? -v : v;
  endfunction

  // Configuration registers.
  fct_pkg::point_t                 origin;
  logic [3*fct_pkg::DIR_W-1:0]     axis_p;
  logic [3*fct_pkg::DIR_W-1:0]     up_p;

  // Sequencer state and working registers.
  fct_pkg::basis_state_t state, state_next;
  fct_pkg::mul_phase_t   mphase;
  logic [3:0]            k;
  logic                  degen;
  logic                  nsel;
  logic signed [TW-1:0]  t [3];
  logic signed [TW-1:0]  ax2;
  logic signed [WW-1:0]  wl;
  fct_pkg::dir_t         w [3];
  logic [TW-1:0]         rm [3];
  logic                  neg [3];
  logic [TW-1:0]         s2;
  logic [TW-1:0]         sq_x, sq_r, sq_bit;
  logic [TW-1:0]         d_num, d_rem;
  logic [5:0]            d_cnt;
  logic [WW-1:0]         m_a, m_acc;
  logic [TW-1:0]         m_b;
  logic                  m_neg;
  logic [5:0]            m_cnt;
  fct_pkg::vec_t         bx, by, bz;

  fct_pkg::dir_t         a [3];
  fct_pkg::dir_t         u [3];
  logic                  degen_now;
  logic signed [TW-1:0]  op_a, op_b, d_mag;
  logic [TW-1:0]         op_a_mag, op_b_mag;
  logic signed [WW-1:0]  prod;
  logic [TW-1:0]         p64;
  logic                  mul_last;
  logic                  big;
  logic [TW-1:0]         sq_sum;
  logic [TW-1:0]         rem_sh;
  logic [TW-1:0]         q_div, u_div;
  logic signed [TW-1:0]  ysum, yr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      axis_p <= (3*fct_pkg::DIR_W)'(1) << (fct_pkg::DIR_W - 2);
      up_p   <= (3*fct_pkg::DIR_W)'(1) << (2*fct_pkg::DIR_W - 2);
    end else if (cfg_we) begin
      case (cfg_index)
        fct_pkg::CFG_ORIGIN_X: origin[0] <= cfg_data[fct_pkg::COORD_W-1:0];
        fct_pkg::CFG_ORIGIN_Y: origin[1] <= cfg_data[fct_pkg::COORD_W-1:0];
        fct_pkg::CFG_ORIGIN_Z: origin[2] <= cfg_data[fct_pkg::COORD_W-1:0];
        fct_pkg::CFG_AXIS:     axis_p    <= cfg_data[3*fct_pkg::DIR_W-1:0];
        fct_pkg::CFG_UP:       up_p      <= cfg_data[3*fct_pkg::DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Direction components.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = axis_p[i*fct_pkg::DIR_W +: fct_pkg::DIR_W];
      u[i] = up_p[i*fct_pkg::DIR_W +: fct_pkg::DIR_W];
    end
  end

  assign degen_now = (axis_p == '0) || (up_p == '0);

  // Operand selection for the shared serial multiplier.
  always_comb begin
    d_mag = t[2][TW-1] ? -t[2] : t[2];
    op_a  = '0;
    op_b  = '0;
    case (mphase)
      fct_pkg::MP_SQ: begin
        case (k)
          4'd0: begin op_a = TW'(a[0]); op_b = TW'(a[0]); end
          4'd1: begin op_a = TW'(a[1]); op_b = TW'(a[1]); end
          4'd2: begin op_a = TW'(a[2]); op_b = TW'(a[2]); end
          4'd3: begin op_a = TW'(u[0]); op_b = TW'(u[0]); end
          4'd4: begin op_a = TW'(u[1]); op_b = TW'(u[1]); end
          4'd5: begin op_a = TW'(u[2]); op_b = TW'(u[2]); end
          4'd6: begin op_a = TW'(a[0]); op_b = TW'(u[0]); end
          4'd7: begin op_a = TW'(a[1]); op_b = TW'(u[1]); end
          default: begin op_a = TW'(a[2]); op_b = TW'(u[2]); end
        endcase
      end
      fct_pkg::MP_PAR: begin
        if (k == 4'd0) begin
          op_a = d_mag * 64'sd50;
          op_b = d_mag * 64'sd50;
        end else begin
          op_a = t[0] * 64'sd2401;
          op_b = t[1];
        end
      end
      fct_pkg::MP_CROSS: begin
        case (k)
          4'd0: begin op_a = TW'(a[1]); op_b = TW'(w[2]); end
          4'd1: begin op_a = TW'(a[2]); op_b = TW'(w[1]); end
          4'd2: begin op_a = TW'(a[2]); op_b = TW'(w[0]); end
          4'd3: begin op_a = TW'(a[0]); op_b = TW'(w[2]); end
          4'd4: begin op_a = TW'(a[0]); op_b = TW'(w[1]); end
          default: begin op_a = TW'(a[1]); op_b = TW'(w[0]); end
        endcase
      end
      fct_pkg::MP_NORM: begin
        op_a = rm[k[1:0]];
        op_b = rm[k[1:0]];
      end
      default: begin
        case (k)
          4'd0: begin op_a = TW'(bz[1]); op_b = TW'(bx[2]); end
          4'd1: begin op_a = TW'(bz[2]); op_b = TW'(bx[1]); end
          4'd2: begin op_a = TW'(bz[2]); op_b = TW'(bx[0]); end
          4'd3: begin op_a = TW'(bz[0]); op_b = TW'(bx[2]); end
          4'd4: begin op_a = TW'(bz[0]); op_b = TW'(bx[1]); end
          default: begin op_a = TW'(bz[1]); op_b = TW'(bx[0]); end
        endcase
      end
    endcase
    op_a_mag = abs_t(op_a);
    op_b_mag = abs_t(op_b);
  end

  // Helper values of the datapath steps.
  always_comb begin
    prod   = m_neg ? -$signed(m_acc) : $signed(m_acc);
    p64    = prod[TW-1:0];
    big    = (rm[0][TW-1:fct_pkg::NORM_BITS] != '0) ||
             (rm[1][TW-1:fct_pkg::NORM_BITS] != '0) ||
             (rm[2][TW-1:fct_pkg::NORM_BITS] != '0);
    sq_sum = sq_r + sq_bit;
    rem_sh = {d_rem[TW-2:0], d_num[TW-1]};
    q_div  = (sq_r == '0) ? '0 : d_num;
    u_div  = neg[k[1:0]] ? -q_div : q_div;
    ysum   = t[k[2:1]] - $signed(p64);
    yr     = (ysum + Y_HALF) >>> fct_pkg::FRAC;
    unique case (mphase) inside
      fct_pkg::MP_SQ:                     mul_last = (k == 4'd8);
      fct_pkg::MP_PAR:                    mul_last = (k == 4'd1);
      fct_pkg::MP_NORM:                   mul_last = (k == 4'd2);
      fct_pkg::MP_CROSS, fct_pkg::MP_YHAT: mul_last = (k == 4'd5);
      default:                            mul_last = 1'b1;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fct_pkg::BS_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fct_pkg::BS_LOAD:   state_next = degen_now ? fct_pkg::BS_DONE : fct_pkg::BS_MLOAD;
      fct_pkg::BS_MLOAD:  state_next = fct_pkg::BS_MRUN;
      fct_pkg::BS_MRUN:   if (&m_cnt) state_next = fct_pkg::BS_MSTORE;
      fct_pkg::BS_MSTORE: begin
        if (!mul_last) begin
          state_next = fct_pkg::BS_MLOAD;
        end else begin
          unique case (mphase)
            fct_pkg::MP_CROSS: state_next = fct_pkg::BS_SHIFT;
            fct_pkg::MP_NORM:  state_next = fct_pkg::BS_SQRT;
            fct_pkg::MP_YHAT:  state_next = fct_pkg::BS_DONE;
            default:           state_next = fct_pkg::BS_MLOAD;
          endcase
        end
      end
      fct_pkg::BS_SHIFT:  if (!big) state_next = fct_pkg::BS_MLOAD;
      fct_pkg::BS_SQRT:   if (sq_bit[0]) state_next = fct_pkg::BS_DLOAD;
      fct_pkg::BS_DLOAD:  state_next = fct_pkg::BS_DRUN;
      fct_pkg::BS_DRUN:   if (&d_cnt) state_next = fct_pkg::BS_DSTORE;
      fct_pkg::BS_DSTORE: begin
        if (k == 4'd2) begin
          state_next = nsel ? fct_pkg::BS_MLOAD : fct_pkg::BS_SHIFT;
        end else begin
          state_next = fct_pkg::BS_DLOAD;
        end
      end
      fct_pkg::BS_DONE:   state_next = fct_pkg::BS_DONE;
      default:            state_next = fct_pkg::BS_LOAD;
    endcase
    if (cfg_we) begin
      state_next = fct_pkg::BS_LOAD;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      fct_pkg::BS_LOAD: begin
        degen  <= degen_now;
        mphase <= fct_pkg::MP_SQ;
        k      <= '0;
      end

      fct_pkg::BS_MLOAD: begin
        m_a   <= {{(WW-TW){1'b0}}, op_a_mag};
        m_b   <= op_b_mag;
        m_neg <= op_a[TW-1] ^ op_b[TW-1];
        m_acc <= '0;
        m_cnt <= '0;
      end

      // One multiplier bit per cycle.
      fct_pkg::BS_MRUN: begin
        if (m_b[0]) begin
          m_acc <= m_acc + m_a;
        end
        m_a   <= m_a << 1;
        m_b   <= m_b >> 1;
        m_cnt <= m_cnt + 6'd1;
      end

      fct_pkg::BS_MSTORE: begin
        k <= mul_last ? 4'd0 : k + 4'd1;
        case (mphase)
          fct_pkg::MP_SQ: begin
            case (k) inside
              4'd0: begin t[0] <= p64; ax2 <= p64; end
              4'd1, 4'd2: t[0] <= t[0] + $signed(p64);
              4'd3: t[1] <= p64;
              4'd4, 4'd5: t[1] <= t[1] + $signed(p64);
              4'd6: t[2] <= p64;
              default: t[2] <= t[2] + $signed(p64);
            endcase
            if (mul_last) mphase <= fct_pkg::MP_PAR;
          end
          fct_pkg::MP_PAR: begin
            if (k == 4'd0) begin
              wl <= prod;
            end else begin
              // Near parallel: pick a substitute up direction.
              if ($unsigned(wl) > $unsigned(prod)) begin
                if (64'sd2500 * ax2 > 64'sd2401 * t[0]) begin
                  w[0] <= '0;
                  w[1] <= '0;
                  w[2] <= fct_pkg::dir_t'(1);
                end else begin
                  w[0] <= '1;
                  w[1] <= '0;
                  w[2] <= '0;
                end
              end else begin
                w <= u;
              end
              mphase <= fct_pkg::MP_CROSS;
            end
          end
          fct_pkg::MP_CROSS: begin
            t[k[2:1]] <= k[0] ? t[k[2:1]] - $signed(p64) : $signed(p64);
            if (mul_last) begin
              for (int i = 0; i < 3; i++) begin
                rm[i]  <= abs_t(TW'(a[i]));
                neg[i] <= a[i][fct_pkg::DIR_W-1];
              end
              nsel <= 1'b0;
            end
          end
          fct_pkg::MP_NORM: begin
            s2 <= (k == 4'd0) ? p64 : s2 + p64;
            if (mul_last) begin
              sq_x   <= (s2 + p64) << fct_pkg::NORM_BITS;
              sq_r   <= '0;
              sq_bit <= TW'(1) << (TW - 2);
            end
          end
          default: begin
            if (!k[0]) begin
              t[k[2:1]] <= p64;
            end else begin
              by[k[2:1]] <= yr[fct_pkg::BW-1:0];
            end
          end
        endcase
      end

      // Bring every magnitude below the normalization range.
      fct_pkg::BS_SHIFT: begin
        if (big) begin
          for (int i = 0; i < 3; i++) begin
            rm[i] <= rm[i] >> 1;
          end
        end else begin
          mphase <= fct_pkg::MP_NORM;
          k      <= '0;
        end
      end

      // Square root, one result bit per cycle.
      fct_pkg::BS_SQRT: begin
        if (sq_x >= sq_sum) begin
          sq_x <= sq_x - sq_sum;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
        k      <= '0;
      end

      fct_pkg::BS_DLOAD: begin
        d_num <= (rm[k[1:0]] << 40) + (sq_r >> 1);
        d_rem <= '0;
        d_cnt <= '0;
      end

      // Restoring division, one quotient bit per cycle.
      fct_pkg::BS_DRUN: begin
        if (rem_sh >= sq_r) begin
          d_rem <= rem_sh - sq_r;
          d_num <= {d_num[TW-2:0], 1'b1};
        end else begin
          d_rem <= rem_sh;
          d_num <= {d_num[TW-2:0], 1'b0};
        end
        d_cnt <= d_cnt + 6'd1;
      end

      fct_pkg::BS_DSTORE: begin
        if (nsel) begin
          bz[k[1:0]] <= u_div[fct_pkg::BW-1:0];
        end else begin
          bx[k[1:0]] <= u_div[fct_pkg::BW-1:0];
        end
        if (k == 4'd2) begin
          k <= '0;
          if (nsel) begin
            mphase <= fct_pkg::MP_YHAT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              rm[i]  <= abs_t(t[i]);
              neg[i] <= t[i][TW-1];
            end
            nsel <= 1'b1;
          end
        end else begin
          k <= k + 4'd1;
        end
      end

      default: ;
    endcase
  end

  assign frame.ready  = (state == fct_pkg::BS_DONE);
  assign frame.degen  = degen;
  assign frame.origin = origin;
  assign frame.bx     = bx;
  assign frame.by     = by;
  assign frame.bz     = bz;

endmodule

`default_nettype wire

// ===== rtl/core/fct_front.sv =====
`default_nettype none

module fct_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  fct_pkg::in_item_t in_data,
  input  fct_pkg::frame_t   frame,
  input  logic              q_full,
  output logic              push,
  output fct_pkg::q_item_t  push_item
);

  // Points wait while the basis is rebuilt or the queue is full.
  assign in_stall = !frame.ready || q_full;
  assign push     = in_valid && !in_stall;

  // Tag each point with its direction and the frame's degenerate flag.
  always_comb begin
    push_item.func  = in_data.func;
    push_item.degen = frame.degen;
    push_item.pt[0] = in_data.in_x;
    push_item.pt[1] = in_data.in_y;
    push_item.pt[2] = in_data.in_z;
  end

endmodule

`default_nettype wire

// ===== rtl/core/fct_queue.sv =====
`default_nettype none

module fct_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  fct_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output fct_pkg::q_item_t head
);

  fct_pkg::q_item_t         mem [fct_pkg::Q_DEPTH];
  logic [fct_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [fct_pkg::Q_AW:0]   count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  assign full  = (count == (fct_pkg::Q_AW+1)'(fct_pkg::Q_DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/core/fct_back.sv =====
`default_nettype none

module fct_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  fct_pkg::q_item_t   q_head,
  output logic               pop,
  input  fct_pkg::frame_t    frame,
  output logic               out_valid,
  input  logic               out_stall,
  output fct_pkg::out_item_t out_data
);

  localparam int CW    = fct_pkg::COORD_W;
  localparam int PW    = CW + 1 + fct_pkg::BW;
  localparam int ACC_W = PW + 2;
  localparam int VW    = ACC_W - fct_pkg::FRAC;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (fct_pkg::FRAC - 1);
  localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  logic                   adv;
  fct_pkg::vec_t          bas [3];

  logic                   s1_valid, s2_valid;
  logic                   s1_degen, s2_degen;
  logic signed [CW:0]     s1_opv  [3];
  fct_pkg::coef_t         s1_coef [3][3];
  fct_pkg::coord_t        s1_bias [3];
  logic signed [PW-1:0]   s2_prod [3][3];
  fct_pkg::coord_t        s2_bias [3];

  logic signed [CW:0]     opv  [3];
  fct_pkg::coef_t         coef [3][3];
  fct_pkg::coord_t        bias [3];
  logic signed [ACC_W-1:0] sum [3];
  logic signed [VW-1:0]   v    [3];
  logic [CW-1:0]          res  [3];

  // The whole pipeline moves when the output register can take a transfer.
  assign adv = !out_valid || !out_stall;
  assign pop = q_valid && adv;

  assign bas[0] = frame.bx;
  assign bas[1] = frame.by;
  assign bas[2] = frame.bz;

  // Operand and coefficient selection by direction.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (q_head.func == fct_pkg::FUNC_TO_FRAME) begin
        opv[j]  = (CW+1)'(q_head.pt[j]) - (CW+1)'(frame.origin[j]);
        bias[j] = '0;
      end else begin
        opv[j]  = (CW+1)'(q_head.pt[j]);
        bias[j] = frame.origin[j];
      end
      for (int i = 0; i < 3; i++) begin
        coef[i][j] = (q_head.func == fct_pkg::FUNC_TO_FRAME) ? bas[i][j] : bas[j][i];
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Stage one: operands; stage two: products.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_degen <= q_head.degen;
      s1_opv   <= opv;
      s1_coef  <= coef;
      s1_bias  <= bias;
      s2_degen <= s1_degen;
      s2_bias  <= s1_bias;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s2_prod[i][j] <= PW'(s1_opv[j]) * PW'(s1_coef[i][j]);
        end
      end
    end
  end

  // Sum, round half up and saturate.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = ACC_W'(s2_prod[i][0]) + ACC_W'(s2_prod[i][1]) + ACC_W'(s2_prod[i][2]) +
               (ACC_W'(s2_bias[i]) <<< fct_pkg::FRAC) + HALF;
      v[i]   = sum[i][ACC_W-1:fct_pkg::FRAC];
      if ((&v[i][VW-1:CW-1]) || !(|v[i][VW-1:CW-1])) begin
        res[i] = v[i][CW-1:0];
      end else begin
        res[i] = v[i][VW-1] ? SAT_MIN : SAT_MAX;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_x      <= s2_degen ? '0 : res[0];
      out_data.out_y      <= s2_degen ? '0 : res[1];
      out_data.out_z      <= s2_degen ? '0 : res[2];
      out_data.degenerate <= s2_degen;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/frame_coordinate_transform_core.sv =====
`default_nettype none

// Converts Q16.16 points between world coordinates and a local frame set by an
// origin, an axis and an up direction; func 0 maps frame to world, func 1 maps
// world to frame, and results are rounded and saturated. The basis is built
// from the configuration registers by a sequencer around one serial
// multiplier, a bit-serial square root and a restoring divider, which runs
// after reset and after every configuration write; in_stall stays high
// until the basis is ready. Once the basis is ready the block takes one point
// per cycle, limited only by the output side, and a point passes through the
// four-entry input queue and then the three registered operand, product and
// sum stages of the datapath.
module frame_coordinate_transform_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fct_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  fct_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output fct_pkg::out_item_t            out_data
);

  fct_pkg::frame_t  frame;
  fct_pkg::q_item_t push_item, q_head;
  logic             push, q_full, q_valid, pop;

  fct_basis u_basis (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame     (frame)
  );

  fct_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .frame     (frame),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  fct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  fct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .frame     (frame),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A configuration write always starts a basis rebuild.
  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !frame.ready)
    else $error("basis still marked ready after a configuration write");

  // Points are only taken against a finished basis.
  a_accept_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> frame.ready)
    else $error("point transfer while the basis is being rebuilt");

  // A degenerate frame gives a zero point.
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.degenerate) |->
      (out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0))
    else $error("degenerate result with a nonzero coordinate");

endmodule

`default_nettype wire

// ===== tb/frame_coordinate_transform_core_test.sv =====
`default_nettype none

module frame_coordinate_transform_core_test;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_ITEMS = 1600;
  localparam int TAIL_CYCLES = 20;
  localparam int IDLE_PCT = 21;
  localparam int HOLD_AT = 400;
  localparam int HOLD_LEN = 400;
  localparam logic [fct_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [fct_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic FUNC_TO_WORLD = 1'b0;

  typedef longint trip_t [3];

  typedef struct {
    bit                            is_cfg;
    logic [fct_pkg::CFG_IDX_W-1:0] idx;
    logic [fct_pkg::CFG_W-1:0]     data;
    fct_pkg::in_item_t             item;
  } stim_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [fct_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fct_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  fct_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fct_pkg::out_item_t out_data;

  stim_op_t pending_ops[$];
  fct_pkg::out_item_t expected_points[$];
  int n_sent = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_degen = 0;
  int n_errors = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // Frame configuration as the predictor sees it.
  fct_pkg::coord_t org_r[3];
  logic [3*fct_pkg::DIR_W-1:0] axis_r, up_r;

  frame_coordinate_transform_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // Scales a vector to Q2.30 unit length after bringing it below 20 bits.
  function automatic trip_t unit_vec(trip_t v);
    longint unsigned m[3], r[3], mx, s2, n, q;
    int s;
    trip_t u;
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> s) >= (64'd1 << fct_pkg::NORM_BITS)) s++;
    for (int i = 0; i < 3; i++) r[i] = m[i] >> s;
    s2 = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    n = int_sqrt(s2 << 20);
    for (int i = 0; i < 3; i++) begin
      q = (n == 0) ? 0 : ((r[i] << 40) + n / 2) / n;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic trip_t split_dir(logic [3*fct_pkg::DIR_W-1:0] p);
    trip_t d;
    for (int i = 0; i < 3; i++)
      d[i] = longint'(fct_pkg::dir_t'(p[i*fct_pkg::DIR_W +: fct_pkg::DIR_W]));
    return d;
  endfunction

  // Computes the transformed point for the current frame configuration.
  function automatic fct_pkg::out_item_t transform_point(fct_pkg::in_item_t it);
    trip_t a, u, w, c, bx, by, bz, pt, org;
    longint bas[3][3];
    longint unsigned a2, u2, d, ax2;
    longint dot;
    logic [127:0] lhs, rhs;
    logic signed [127:0] acc;
    fct_pkg::coord_t res[3];
    fct_pkg::out_item_t o;
    a = split_dir(axis_r);
    u = split_dir(up_r);
    o = '0;
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (u[0] == 0 && u[1] == 0 && u[2] == 0)) begin
      o.degenerate = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) org[i] = longint'(org_r[i]);
    pt[0] = longint'(it.in_x);
    pt[1] = longint'(it.in_y);
    pt[2] = longint'(it.in_z);
    a2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    u2 = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
    dot = a[0] * u[0] + a[1] * u[1] + a[2] * u[2];
    d = (dot < 0) ? -dot : dot;
    // Replace up when it is too close to the axis.
    lhs = 50 * d;
    lhs = lhs * lhs;
    rhs = 2401 * a2;
    rhs = rhs * u2;
    w = u;
    if (lhs > rhs) begin
      ax2 = a[0] * a[0];
      if (2500 * ax2 > 2401 * a2) begin
        w[0] = 0; w[1] = 0; w[2] = 1;
      end else begin
        w[0] = -1; w[1] = 0; w[2] = 0;
      end
    end
    c[0] = a[1] * w[2] - a[2] * w[1];
    c[1] = a[2] * w[0] - a[0] * w[2];
    c[2] = a[0] * w[1] - a[1] * w[0];
    bx = unit_vec(a);
    bz = unit_vec(c);
    by[0] = (bz[1] * bx[2] - bz[2] * bx[1] + (64'sd1 <<< 29)) >>> 30;
    by[1] = (bz[2] * bx[0] - bz[0] * bx[2] + (64'sd1 <<< 29)) >>> 30;
    by[2] = (bz[0] * bx[1] - bz[1] * bx[0] + (64'sd1 <<< 29)) >>> 30;
    for (int i = 0; i < 3; i++) begin
      bas[0][i] = bx[i];
      bas[1][i] = by[i];
      bas[2][i] = bz[i];
    end
    // Accumulate at full precision, then round and saturate.
    for (int i = 0; i < 3; i++) begin
      if (it.func == fct_pkg::FUNC_TO_FRAME) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc = acc + (pt[j] - org[j]) * bas[i][j];
      end else begin
        acc = org[i] * (64'sd1 <<< 30);
        for (int j = 0; j < 3; j++) acc = acc + pt[j] * bas[j][i];
      end
      acc = (acc + (128'sd1 <<< 29)) >>> 30;
      if (acc > 128'sd2147483647) res[i] = 32'h7fffffff;
      else if (acc < -128'sd2147483648) res[i] = 32'h80000000;
      else res[i] = acc[31:0];
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    return o;
  endfunction

  function automatic void apply_cfg(logic [fct_pkg::CFG_IDX_W-1:0] idx,
                                    logic [fct_pkg::CFG_W-1:0] data);
    case (idx)
      fct_pkg::CFG_ORIGIN_X: org_r[0] = data[fct_pkg::COORD_W-1:0];
      fct_pkg::CFG_ORIGIN_Y: org_r[1] = data[fct_pkg::COORD_W-1:0];
      fct_pkg::CFG_ORIGIN_Z: org_r[2] = data[fct_pkg::COORD_W-1:0];
      fct_pkg::CFG_AXIS:     axis_r = data[3*fct_pkg::DIR_W-1:0];
      fct_pkg::CFG_UP:       up_r = data[3*fct_pkg::DIR_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [3*fct_pkg::DIR_W-1:0] pack_dir(int x, int y, int z);
    fct_pkg::dir_t dx, dy, dz;
    dx = fct_pkg::dir_t'(x);
    dy = fct_pkg::dir_t'(y);
    dz = fct_pkg::dir_t'(z);
    return {dz, dy, dx};
  endfunction

  task automatic add_cfg(logic [fct_pkg::CFG_IDX_W-1:0] idx, logic [fct_pkg::CFG_W-1:0] data);
    stim_op_t op;
    op.is_cfg = 1'b1;
    op.idx = idx;
    op.data = data;
    op.item = '0;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  task automatic add_point(logic func, fct_pkg::coord_t x, fct_pkg::coord_t y,
                           fct_pkg::coord_t z);
    stim_op_t op;
    op.is_cfg = 1'b0;
    op.idx = '0;
    op.data = '0;
    op.item.func = func;
    op.item.in_x = x;
    op.item.in_y = y;
    op.item.in_z = z;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // Upper data bits above the register width are random and must be ignored.
  task automatic add_frame(fct_pkg::coord_t ox, fct_pkg::coord_t oy, fct_pkg::coord_t oz,
                           logic [3*fct_pkg::DIR_W-1:0] ax, logic [3*fct_pkg::DIR_W-1:0] up);
    add_cfg(fct_pkg::CFG_ORIGIN_X, {16'($urandom), ox});
    add_cfg(fct_pkg::CFG_ORIGIN_Y, {16'($urandom), oy});
    add_cfg(fct_pkg::CFG_ORIGIN_Z, {16'($urandom), oz});
    add_cfg(fct_pkg::CFG_AXIS, ax);
    add_cfg(fct_pkg::CFG_UP, up);
  endtask

  function automatic fct_pkg::coord_t rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h7ff) - 32'h400;
      default: return fct_pkg::coord_t'($urandom_range(32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  function automatic logic [3*fct_pkg::DIR_W-1:0] rand_dir();
    if ($urandom_range(1)) return (3*fct_pkg::DIR_W)'({$urandom, $urandom});
    return pack_dir($urandom_range(400) - 200, $urandom_range(400) - 200,
                    $urandom_range(400) - 200);
  endfunction

  // Driver: offers queued points and applies register writes when the block is empty.
  always @(posedge clk) begin
    bit taken;
    bit quiet;
    stim_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        expected_points.insert(expected_points.size(), transform_point(in_data));
        n_sent <= n_sent + 1;
      end
      quiet = (n_sent >= 700 && n_sent < 1000);
      if (in_valid && !taken) begin
        cfg_we <= 1'b0;
      end else if (pending_ops.size() != 0 && pending_ops[0].is_cfg) begin
        if (!in_valid && n_sent == n_checked) begin
          op = pending_ops.pop_front();
          apply_cfg(op.idx, op.data);
          cfg_we <= 1'b1;
          cfg_index <= op.idx;
          cfg_data <= op.data;
          n_cfg <= n_cfg + 1;
        end else begin
          cfg_we <= 1'b0;
        end
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        op = pending_ops.pop_front();
        cfg_we <= 1'b0;
        in_valid <= 1'b1;
        in_data <= op.item;
      end else begin
        cfg_we <= 1'b0;
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  always @(posedge clk) begin
    fct_pkg::out_item_t exp_pt;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $error("result transfer with no prediction pending");
          n_errors <= n_errors + 1;
        end else begin
          exp_pt = expected_points.pop_front();
          if (exp_pt.degenerate) n_degen <= n_degen + 1;
          if (out_data.out_x !== exp_pt.out_x) begin
            $error("out_x expected %0d actual %0d", exp_pt.out_x, out_data.out_x);
            n_errors <= n_errors + 1;
          end
          if (out_data.out_y !== exp_pt.out_y) begin
            $error("out_y expected %0d actual %0d", exp_pt.out_y, out_data.out_y);
            n_errors <= n_errors + 1;
          end
          if (out_data.out_z !== exp_pt.out_z) begin
            $error("out_z expected %0d actual %0d", exp_pt.out_z, out_data.out_z);
            n_errors <= n_errors + 1;
          end
          if (out_data.degenerate !== exp_pt.degenerate) begin
            $error("degenerate expected %0b actual %0b", exp_pt.degenerate,
                   out_data.degenerate);
            n_errors <= n_errors + 1;
          end
        end
        n_checked <= n_checked + 1;
      end
      // One long hold-off lets the block fill up and stall its input.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && n_checked >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !(n_checked >= 700 && n_checked < 1000) &&
                     ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("frame_coordinate_transform_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    int per_phase;
    org_r[0] = '0;
    org_r[1] = '0;
    org_r[2] = '0;
    axis_r = pack_dir(1 << (fct_pkg::DIR_W - 2), 0, 0);
    up_r = pack_dir(0, 1 << (fct_pkg::DIR_W - 2), 0);

    // Reset frame: field extremes in both directions.
    for (int f = 0; f < 2; f++) begin
      add_point(f[0], 0, 0, 0);
      add_point(f[0], 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      add_point(f[0], 32'h80000000, 32'h7fffffff, 32'h80000000);
      add_point(f[0], 32'hffffffff, 32'h00000001, 32'h00010000);
    end
    // Extreme origins and directions, with saturation.
    add_frame(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              pack_dir(32767, 32767, 32767), pack_dir(-32768, 32767, -32768));
    add_cfg(CFG_SPARE_LO, (fct_pkg::CFG_W)'({$urandom, $urandom}));
    add_cfg(CFG_SPARE_HI, (fct_pkg::CFG_W)'({$urandom, $urandom}));
    add_point(FUNC_TO_WORLD, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_point(fct_pkg::FUNC_TO_FRAME, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_point(fct_pkg::FUNC_TO_FRAME, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_point(FUNC_TO_WORLD, 32'h80000000, 32'h80000000, 32'h80000000);
    // Zero axis, then zero up: degenerate frame.
    add_frame(32'h00010000, 0, 0, '0, pack_dir(0, 5, 0));
    add_point(FUNC_TO_WORLD, 32'h7fffffff, 0, 32'h80000000);
    add_point(fct_pkg::FUNC_TO_FRAME, 32'h12345678, 32'h80000000, 0);
    add_frame(0, 32'hffff0000, 0, pack_dir(-32768, -32768, -32768), '0);
    add_point(fct_pkg::FUNC_TO_FRAME, 1, 2, 3);
    // Up parallel to an axis away from the x line.
    add_frame(0, 0, 32'h00020000, pack_dir(0, 1000, 0), pack_dir(0, -2000, 1));
    add_point(FUNC_TO_WORLD, 32'h00010000, 32'h00020000, 32'hfffd0000);
    add_point(fct_pkg::FUNC_TO_FRAME, 32'h00010000, 32'h00020000, 32'hfffd0000);
    // Up parallel to an axis near the x line.
    add_frame(32'hfff00000, 0, 0, pack_dir(1000, 10, 0), pack_dir(-2000, 0, 0));
    add_point(FUNC_TO_WORLD, 32'h00010000, 32'h00020000, 32'hfffd0000);
    add_point(fct_pkg::FUNC_TO_FRAME, 32'h00010000, 32'h00020000, 32'hfffd0000);

    // Random frames, mostly with proper directions; an occasional zero direction.
    per_phase = RAND_ITEMS / 10;
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 7) begin
        add_frame(rand_coord(), rand_coord(), rand_coord(), rand_dir(), '0);
      end else if (ph == 3) begin
        add_frame(rand_coord(), rand_coord(), rand_coord(), pack_dir(300, 2, -1),
                  pack_dir(-600, -3, 2));
      end else begin
        add_frame(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir());
      end
      if (ph == 5) add_cfg(CFG_SPARE_LO + 3'd1, (fct_pkg::CFG_W)'({$urandom, $urandom}));
      for (int k = 0; k < per_phase; k++)
        add_point(1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
    end

    @(posedge clk);
    @(posedge clk);
    @(posedge clk);
    rst <= 1'b0;
    while (pending_ops.size() != 0 || in_valid || cfg_we || n_sent != n_checked)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_points.size() != 0) begin
      $error("%0d predicted results never arrived", expected_points.size());
      n_errors = n_errors + 1;
    end
    $display("Checked %0d transformed points (%0d degenerate) over %0d register writes,",
             n_checked, n_degen, n_cfg);
    $display("both directions, saturating origins, parallel up fallbacks and zero frames.");
    if (n_errors == 0) begin
      $display("frame_coordinate_transform_core_test: done, clean");
    end else begin
      $display("frame_coordinate_transform_core_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/fct_pkg.sv
rtl/core/fct_basis.sv
rtl/core/fct_front.sv
rtl/core/fct_queue.sv
rtl/core/fct_back.sv
rtl/core/frame_coordinate_transform_core.sv
tb/frame_coordinate_transform_core_test.sv
